// ===== rtl/orc_pkg.sv =====
`default_nettype none
package orc_pkg;

  // built depth of the table
  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [2:0] {
    REQ_INC    = 3'd0,
    REQ_DEC    = 3'd1,
    REQ_SINGLE = 3'd2,
    REQ_VALID  = 3'd3,
    REQ_CLEAR  = 3'd4
  } req_code_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NULL     = 3'd1,
    ST_OWNER    = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTMAN   = 3'd4,
    ST_CLEARED  = 3'd5
  } status_code_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EXEC,
    S_CLEAR
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/orc_if.sv =====
`default_nettype none
interface orc_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic signed [31:0] owner_id;
  logic [31:0]        buffer_ptr;

  modport source (output valid, req_type, owner_id, buffer_ptr, input ready);
  modport sink (input valid, req_type, owner_id, buffer_ptr, output ready);
endinterface

interface orc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_ptr;
  logic [2:0]  status;
  logic        answer;
  logic        released;
  logic [5:0]  cleared_count;
  logic        last;

  modport source (output valid, result_ptr, status, answer, released, cleared_count, last,
                  input ready);
  modport sink (input valid, result_ptr, status, answer, released, cleared_count, last,
                output ready);
endinterface
`default_nettype wire

// ===== rtl/owned_pointer_refcount_table_top.sv =====
// reference count table for buffer pointers, with an owner per entry
// channels: req (sink) takes one request transaction (req_type, owner_id,
// buffer_ptr); rsp (source) gives result transactions, the final one of each
// request with last = 1. cfg_we/cfg_data write table_size; the user must do so only
// while the block is idle, as the block does not enforce it. a request is taken only
// when the block is idle (req.ready high). lookups (increment, decrement, is single,
// is valid) scan the used entries one per cycle through a single compare unit, then
// resolve the request in S_EXEC, which waits for a free output register; the result
// lands in the output register as req.ready returns. the block takes one request at a
// time: the next is taken only once the last result has been loaded
// clear by owner walks the same scan and emits one result per released entry,
// then the final count; a released entry holds the scan while rsp stalls
// the output register frees the next request from the receiver: while rsp
// stalls, the block may accept and scan the next request, and holds its
// update until the pending result is taken
// reset clears all entries (pointer zero means free) and sets table_size to 32,
// with no sweep: the block is ready as soon as reset drops
`default_nettype none
module owned_pointer_refcount_table_top
  import orc_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire [5:0]  cfg_data,
  orc_req_if.sink    req,
  orc_rsp_if.source  rsp
);

  // table store, one compare path reads it at one address
  logic [31:0] slot_pointer [TABLE_DEPTH];
  logic [31:0] slot_owner   [TABLE_DEPTH];
  logic [31:0] slot_refs    [TABLE_DEPTH];

  logic [5:0] table_size;

  state_t state, state_next;

  // latched request
  logic [2:0]  cur_req;
  logic [31:0] cur_owner;
  logic [31:0] cur_ptr;

  // scan bookkeeping
  logic [CNT_W-1:0] idx;
  logic [CNT_W-1:0] count;
  logic             hit;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  // output register
  logic        out_valid;
  logic [31:0] out_ptr;
  logic [2:0]  out_status;
  logic        out_answer;
  logic        out_released;
  logic [5:0]  out_count;
  logic        out_last;

  // datapath controls
  logic [CNT_W-1:0] used_cnt;
  logic             scan_live;
  logic             out_free;
  logic [IDX_W-1:0] rd_addr;
  logic [31:0]      e_ptr, e_own, e_refs;
  logic             step;
  logic             clr_hit;
  logic             out_load;
  logic [31:0]      nxt_ptr;
  logic [2:0]       nxt_status;
  logic             nxt_answer, nxt_released, nxt_last;
  logic [5:0]       nxt_count;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [31:0]      wr_ptr, wr_own, wr_refs;

  // entries in use: sizes above the built depth clip to it
  assign used_cnt  = (table_size > 6'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                     : CNT_W'(table_size);
  assign scan_live = idx < used_cnt;
  assign out_free  = !out_valid || rsp.ready;

  // one read address: scan index while walking, found entry for the update
  assign rd_addr = (state == S_EXEC) ? hit_idx : idx[IDX_W-1:0];
  assign e_ptr   = slot_pointer[rd_addr];
  assign e_own   = slot_owner[rd_addr];
  assign e_refs  = slot_refs[rd_addr];

  assign req.ready = (state == S_IDLE);

  assign rsp.valid         = out_valid;
  assign rsp.result_ptr    = out_ptr;
  assign rsp.status        = out_status;
  assign rsp.answer        = out_answer;
  assign rsp.released      = out_released;
  assign rsp.cleared_count = out_count;
  assign rsp.last          = out_last;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          state_next = (req.req_type == REQ_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (!scan_live) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (!scan_live && out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and table writes
  always_comb begin
    step         = 1'b0;
    clr_hit      = 1'b0;
    out_load     = 1'b0;
    nxt_ptr      = '0;
    nxt_status   = ST_OK;
    nxt_answer   = 1'b0;
    nxt_released = 1'b0;
    nxt_count    = '0;
    nxt_last     = 1'b1;
    wr_en        = 1'b0;
    wr_addr      = hit_idx;
    wr_ptr       = e_ptr;
    wr_own       = e_own;
    wr_refs      = e_refs;
    case (state)
      S_SCAN: begin
        step = scan_live;
      end
      S_EXEC: begin
        out_load = out_free;
        if (cur_req > REQ_CLEAR) begin
          nxt_status = ST_OK;
        end else if (cur_ptr == '0) begin
          nxt_status = ST_NULL;
        end else begin
          case (cur_req)
            REQ_INC: begin
              if (!hit) begin
                if (!free_found) begin
                  nxt_status = ST_FULL;
                end else begin
                  wr_en   = out_free;
                  wr_addr = free_idx;
                  wr_ptr  = cur_ptr;
                  wr_own  = cur_owner;
                  wr_refs = 32'd1;
                  nxt_ptr = cur_ptr;
                end
              end else if (e_own != cur_owner) begin
                nxt_status = ST_OWNER;
              end else begin
                wr_en   = out_free;
                wr_refs = e_refs + 32'd1;
                nxt_ptr = cur_ptr;
              end
            end
            REQ_DEC: begin
              if (!hit) begin
                nxt_status = ST_NOTMAN;
              end else if (e_own != cur_owner) begin
                nxt_status = ST_OWNER;
              end else if (e_refs == '0) begin
                nxt_status = ST_NOTMAN;
              end else begin
                wr_en      = out_free;
                wr_refs    = e_refs - 32'd1;
                nxt_answer = 1'b1;
                if (e_refs == 32'd1) begin
                  // last reference gone: free the entry and hand back the pointer
                  wr_ptr       = '0;
                  wr_own       = '0;
                  nxt_ptr      = cur_ptr;
                  nxt_released = 1'b1;
                end
              end
            end
            REQ_SINGLE: begin
              if (!hit) begin
                nxt_status = ST_NOTMAN;
                nxt_answer = 1'b1;
              end else begin
                nxt_answer = (e_refs == 32'd1);
              end
            end
            REQ_VALID: begin
              if (!hit) begin
                nxt_status = ST_NOTMAN;
              end else begin
                nxt_answer = 1'b1;
              end
            end
            default: nxt_status = ST_OK;
          endcase
        end
      end
      S_CLEAR: begin
        wr_addr = idx[IDX_W-1:0];
        wr_ptr  = '0;
        wr_own  = '0;
        wr_refs = '0;
        if (scan_live) begin
          if (e_ptr != '0 && e_own == cur_owner) begin
            // owned entry: release it once the output register is free
            if (out_free) begin
              clr_hit      = 1'b1;
              step         = 1'b1;
              wr_en        = 1'b1;
              out_load     = 1'b1;
              nxt_ptr      = e_ptr;
              nxt_status   = (e_refs != '0) ? ST_CLEARED : ST_OK;
              nxt_released = 1'b1;
              nxt_last     = 1'b0;
            end
          end else begin
            step = 1'b1;
          end
        end else if (out_free) begin
          out_load  = 1'b1;
          nxt_count = 6'(count);
        end
      end
      default: step = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      table_size <= 6'd32;
      out_valid  <= 1'b0;
      idx        <= '0;
      count      <= '0;
      hit        <= 1'b0;
      free_found <= 1'b0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        slot_pointer[i] <= '0;
        slot_owner[i]   <= '0;
        slot_refs[i]    <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        table_size <= cfg_data;
      end
      if (req.valid && req.ready) begin
        cur_req    <= req.req_type;
        cur_owner  <= $unsigned(req.owner_id);
        cur_ptr    <= req.buffer_ptr;
        idx        <= '0;
        count      <= '0;
        hit        <= 1'b0;
        free_found <= 1'b0;
      end else if (step) begin
        idx <= idx + CNT_W'(1);
        // first match and first free entry, in table order
        if (state == S_SCAN && !hit && e_ptr == cur_ptr) begin
          hit     <= 1'b1;
          hit_idx <= idx[IDX_W-1:0];
        end
        if (state == S_SCAN && !free_found && e_ptr == '0) begin
          free_found <= 1'b1;
          free_idx   <= idx[IDX_W-1:0];
        end
        if (clr_hit) begin
          count <= count + CNT_W'(1);
        end
      end
      if (wr_en) begin
        slot_pointer[wr_addr] <= wr_ptr;
        slot_owner[wr_addr]   <= wr_own;
        slot_refs[wr_addr]    <= wr_refs;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ptr      <= nxt_ptr;
      out_status   <= nxt_status;
      out_answer   <= nxt_answer;
      out_released <= nxt_released;
      out_count    <= nxt_count;
      out_last     <= nxt_last;
    end
  end

`ifndef SYNTHESIS
  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> (!out_valid || rsp.ready))
    else $error("result register overwritten while stalled");

  // scan index never runs past the used entry count
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_CLEAR) |-> idx <= used_cnt)
    else $error("scan index beyond used entries");

  // cleared entries never outnumber scanned ones
  a_count_le_idx: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> count <= idx)
    else $error("clear count ahead of scan");

  // a nonzero cleared count only on a final result
  a_count_last: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.cleared_count != 6'd0) |-> rsp.last)
    else $error("cleared count on a non-final result");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request taken while busy");
`endif

endmodule
`default_nettype wire

// ===== tb/owned_pointer_refcount_table_top_test.sv =====
`timescale 1ns / 100ps
module owned_pointer_refcount_table_top_test;
  import orc_pkg::*;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 10;
  // a full scan plus update and output register, with some margin
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
  localparam int REPORT_LIMIT = 10;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_ITEMS = 52;
  localparam int PTR_POOL = 24;
  localparam int OWNER_POOL = 5;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;
  // first request code above the defined operations
  localparam logic [2:0] REQ_UNDEF_LO = 3'd5;
  localparam logic [5:0] SIZE_CODE_MAX = 6'd63;
  localparam req_code_t LOOKUP_OPS [4] = '{REQ_INC, REQ_DEC, REQ_SINGLE, REQ_VALID};

  // one result transaction as seen on the rsp channel
  typedef struct packed {
    logic [31:0] result_ptr;
    logic [2:0]  status;
    logic        answer;
    logic        released;
    logic [5:0]  cleared_count;
    logic        last;
  } refcount_rsp_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [5:0] cfg_data;

  orc_req_if req_bus();
  orc_rsp_if rsp_bus();

  owned_pointer_refcount_table_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .req      (req_bus),
    .rsp      (rsp_bus)
  );

  // shadow copy of the pointer table and its size register
  logic [31:0] tbl_ptr   [TABLE_DEPTH];
  logic [31:0] tbl_owner [TABLE_DEPTH];
  logic [31:0] tbl_refs  [TABLE_DEPTH];
  logic [5:0]  tbl_size;

  // results still owed by the block, oldest first
  refcount_rsp_t refcount_results_q [$];

  // stimulus pools: a few pointers and owners so that lookups hit often
  logic [31:0] ptr_pool   [PTR_POOL];
  logic [31:0] owner_pool [OWNER_POOL];

  // idling controls set by the test tasks; the ready process reads the rsp ones
  bit src_gaps_on;
  bit rsp_gaps_on;
  int rsp_hold_len;

  // run statistics
  int mismatch_cnt;
  int requests_sent;
  int results_seen;
  int releases_seen;
  int status_seen [8];

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // ---------------------------------------------------------------------------
  // shadow table
  // ---------------------------------------------------------------------------

  function automatic void reset_table_model();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      tbl_ptr[i] = '0;
      tbl_owner[i] = '0;
      tbl_refs[i] = '0;
    end
    tbl_size = 6'd32;
  endfunction

  // sizes above the built depth behave as the full depth
  function automatic int live_entries();
    return (tbl_size > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_size);
  endfunction

  // first live entry holding key, -1 when none; key zero finds a free entry
  function automatic int find_slot(input logic [31:0] key);
    int n;
    n = live_entries();
    for (int i = 0; i < n; i++)
      if (tbl_ptr[i] == key) return i;
    return -1;
  endfunction

  function automatic void queue_result(input logic [31:0] ptr, input logic [2:0] status,
                                       input logic answer, input logic released,
                                       input logic [5:0] count, input logic last);
    refcount_rsp_t r;
    r.result_ptr = ptr;
    r.status = status;
    r.answer = answer;
    r.released = released;
    r.cleared_count = count;
    r.last = last;
    refcount_results_q.push_back(r);
  endfunction

  // applies one accepted request to the shadow table and queues its results
  function automatic void compute_refcount_results(input logic [2:0] code,
                                                   input logic [31:0] owner,
                                                   input logic [31:0] ptr);
    int hit;
    int slot_free;
    int n;
    logic [5:0] cleared;
    n = live_entries();
    cleared = '0;

    // clear by owner: one result per released entry, then the count
    if (code == REQ_CLEAR) begin
      for (int i = 0; i < n; i++) begin
        if (tbl_ptr[i] != '0 && tbl_owner[i] == owner) begin
          queue_result(tbl_ptr[i], (tbl_refs[i] != '0) ? ST_CLEARED : ST_OK,
                       1'b0, 1'b1, '0, 1'b0);
          tbl_ptr[i] = '0;
          tbl_owner[i] = '0;
          tbl_refs[i] = '0;
          cleared++;
        end
      end
      queue_result('0, ST_OK, 1'b0, 1'b0, cleared, 1'b1);
      return;
    end

    // undefined codes answer with an empty final result
    if (code > REQ_CLEAR) begin
      queue_result('0, ST_OK, 1'b0, 1'b0, '0, 1'b1);
      return;
    end

    if (ptr == '0) begin
      queue_result('0, ST_NULL, 1'b0, 1'b0, '0, 1'b1);
      return;
    end

    hit = find_slot(ptr);
    case (code)
      REQ_INC: begin
        if (hit < 0) begin
          slot_free = find_slot('0);
          if (slot_free < 0) begin
            queue_result('0, ST_FULL, 1'b0, 1'b0, '0, 1'b1);
            return;
          end
          tbl_ptr[slot_free] = ptr;
          tbl_owner[slot_free] = owner;
          tbl_refs[slot_free] = 32'd1;
        end else if (tbl_owner[hit] != owner) begin
          queue_result('0, ST_OWNER, 1'b0, 1'b0, '0, 1'b1);
          return;
        end else begin
          // count wraps at all ones
          tbl_refs[hit] = tbl_refs[hit] + 32'd1;
        end
        queue_result(ptr, ST_OK, 1'b0, 1'b0, '0, 1'b1);
      end
      REQ_DEC: begin
        if (hit < 0) begin
          queue_result('0, ST_NOTMAN, 1'b0, 1'b0, '0, 1'b1);
        end else if (tbl_owner[hit] != owner) begin
          queue_result('0, ST_OWNER, 1'b0, 1'b0, '0, 1'b1);
        end else if (tbl_refs[hit] == '0) begin
          queue_result('0, ST_NOTMAN, 1'b0, 1'b0, '0, 1'b1);
        end else begin
          tbl_refs[hit] = tbl_refs[hit] - 32'd1;
          if (tbl_refs[hit] == '0) begin
            tbl_ptr[hit] = '0;
            tbl_owner[hit] = '0;
            queue_result(ptr, ST_OK, 1'b1, 1'b1, '0, 1'b1);
          end else begin
            queue_result('0, ST_OK, 1'b1, 1'b0, '0, 1'b1);
          end
        end
      end
      REQ_SINGLE: begin
        // an unknown pointer counts as single
        if (hit < 0)
          queue_result('0, ST_NOTMAN, 1'b1, 1'b0, '0, 1'b1);
        else
          queue_result('0, ST_OK, tbl_refs[hit] == 32'd1, 1'b0, '0, 1'b1);
      end
      default: begin
        if (hit < 0)
          queue_result('0, ST_NOTMAN, 1'b0, 1'b0, '0, 1'b1);
        else
          queue_result('0, ST_OK, 1'b1, 1'b0, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------

  function automatic void log_mismatch(input string what, input refcount_rsp_t want,
                                       input refcount_rsp_t got);
    mismatch_cnt++;
    if (mismatch_cnt <= REPORT_LIMIT)
      $display("%0t: %s: expected ptr=%h status=%0d answer=%0d released=%0d count=%0d last=%0d",
               $time, what, want.result_ptr, want.status, want.answer, want.released,
               want.cleared_count, want.last);
    if (mismatch_cnt <= REPORT_LIMIT)
      $display("%0t: %s:   actual ptr=%h status=%0d answer=%0d released=%0d count=%0d last=%0d",
               $time, what, got.result_ptr, got.status, got.answer, got.released,
               got.cleared_count, got.last);
  endfunction

  // every accepted result transaction is matched against the oldest expectation
  always @(posedge clk) begin
    refcount_rsp_t got;
    refcount_rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got.result_ptr = rsp_bus.result_ptr;
      got.status = rsp_bus.status;
      got.answer = rsp_bus.answer;
      got.released = rsp_bus.released;
      got.cleared_count = rsp_bus.cleared_count;
      got.last = rsp_bus.last;
      results_seen++;
      if (refcount_results_q.size() == 0) begin
        log_mismatch("result with nothing pending", '0, got);
      end else begin
        want = refcount_results_q.pop_front();
        if (got !== want) begin
          log_mismatch("result differs", want, got);
        end else begin
          status_seen[got.status]++;
          if (got.released) releases_seen++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stall bursts, or one long hold when a test asks for it
  // ---------------------------------------------------------------------------

  initial begin : rsp_ready_drive
    int stall_left;
    stall_left = 0;
    rsp_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left == 0 && rsp_hold_len > 0) begin
        stall_left = rsp_hold_len;
        rsp_hold_len = 0;
      end else if (stall_left == 0 && rsp_gaps_on && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(1, 8);
      end
      if (stall_left > 0) begin
        rsp_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // offers one request transaction and returns at the edge that takes it;
  // valid stays up so the next call can follow without a bubble
  task automatic send_request(input logic [2:0] code, input logic [31:0] owner,
                              input logic [31:0] ptr);
    int gap;
    gap = 0;
    if (src_gaps_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.req_type <= code;
    req_bus.owner_id <= owner;
    req_bus.buffer_ptr <= ptr;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    compute_refcount_results(code, owner, ptr);
    requests_sent++;
  endtask

  // sender pause: drop valid and wait for every owed result
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (refcount_results_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // table_size is only written with the block idle
  task automatic write_table_size(input logic [5:0] entries);
    drain_results();
    cfg_we <= 1'b1;
    cfg_data <= entries;
    @(posedge clk);
    cfg_we <= 1'b0;
    tbl_size = entries;
    @(posedge clk);
  endtask

  // pooled traffic: mostly the pointer's usual owner, some stray owners,
  // null pointers, unknown pointers, clears and undefined codes
  task automatic send_random_request();
    int pick;
    int slot;
    logic [31:0] p;
    logic [31:0] o;
    slot = $urandom_range(0, PTR_POOL - 1);
    p = ptr_pool[slot];
    o = owner_pool[slot % OWNER_POOL];
    if ($urandom_range(0, 9) == 0) o = owner_pool[$urandom_range(0, OWNER_POOL - 1)];
    pick = $urandom_range(0, 99);
    if (pick < 40)
      send_request(REQ_INC, o, p);
    else if (pick < 68)
      send_request(REQ_DEC, o, p);
    else if (pick < 76)
      send_request(REQ_SINGLE, o, p);
    else if (pick < 84)
      send_request(REQ_VALID, o, p);
    else if (pick < 87)
      send_request(REQ_CLEAR, o, $urandom());
    else if (pick < 90)
      send_request(LOOKUP_OPS[$urandom_range(0, 3)], o, '0);
    else if (pick < 96)
      send_request(LOOKUP_OPS[$urandom_range(0, 3)], $urandom(), $urandom());
    else if (pick < 98)
      send_request(REQ_UNDEF_LO + 3'($urandom_range(0, 2)), $urandom(), $urandom());
    else
      send_request(REQ_INC, $urandom(), p);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // null pointer on every lookup operation, undefined codes, empty clear
  task automatic test_null_and_unknown();
    write_table_size(6'd32);
    send_request(REQ_INC, 32'h7FFF_FFFF, '0);
    send_request(REQ_DEC, 32'h8000_0000, '0);
    send_request(REQ_SINGLE, 32'hFFFF_FFFF, '0);
    send_request(REQ_VALID, 32'h0000_0000, '0);
    for (int k = 0; k < 3; k++)
      send_request(REQ_UNDEF_LO + 3'(k), 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_CLEAR, 32'h1234_5678, '0);
  endtask

  // one pointer through its whole life, owner checks, unknown-pointer queries
  task automatic test_count_lifecycle();
    logic [31:0] own_a;
    logic [31:0] own_b;
    logic [31:0] p_hi;
    logic [31:0] p_lo;
    own_a = 32'h8000_0000;
    own_b = 32'h7FFF_FFFF;
    p_hi = 32'hFFFF_FFFF;
    p_lo = 32'h0000_0001;
    send_request(REQ_INC, own_a, p_hi);
    send_request(REQ_INC, own_a, p_hi);
    send_request(REQ_SINGLE, own_a, p_hi);
    send_request(REQ_VALID, own_a, p_hi);
    send_request(REQ_INC, own_b, p_hi);     // owner mismatch on increment
    send_request(REQ_DEC, own_b, p_hi);     // owner mismatch on decrement
    send_request(REQ_DEC, own_a, p_hi);     // count 2 -> 1, kept
    send_request(REQ_SINGLE, own_a, p_hi);
    send_request(REQ_DEC, own_a, p_hi);     // released
    send_request(REQ_DEC, own_a, p_hi);     // now unknown
    send_request(REQ_SINGLE, own_a, p_lo);  // unknown counts as single
    send_request(REQ_VALID, own_a, p_lo);
    send_request(REQ_INC, 32'h0, p_lo);
    send_request(REQ_CLEAR, 32'h0, '0);     // clears a live count
  endtask

  // tiny, zero, one and oversized table sizes, hidden entries when shrunk
  task automatic test_size_limits();
    logic [31:0] own_a;
    logic [31:0] own_b;
    own_a = 32'hA5A5_0001;
    own_b = 32'h5A5A_0002;
    write_table_size(6'd2);
    send_request(REQ_INC, own_a, 32'h0000_1000);
    send_request(REQ_INC, own_a, 32'h0000_2000);
    send_request(REQ_INC, own_a, 32'h0000_3000);  // table full
    send_request(REQ_INC, own_a, 32'h0000_1000);
    write_table_size(6'd0);
    send_request(REQ_INC, own_a, 32'h0000_4000);  // nothing in use
    send_request(REQ_VALID, own_a, 32'h0000_1000);
    send_request(REQ_CLEAR, own_a, '0);
    write_table_size(6'd1);
    send_request(REQ_VALID, own_a, 32'h0000_1000);
    send_request(REQ_VALID, own_a, 32'h0000_2000); // hidden above the size
    send_request(REQ_INC, own_b, 32'h0000_2000);
    write_table_size(SIZE_CODE_MAX);
    send_request(REQ_VALID, own_a, 32'h0000_2000);
    send_request(REQ_CLEAR, own_a, '0);
    write_table_size(6'd33);
    send_request(REQ_INC, own_b, 32'h0000_3000);
    send_request(REQ_CLEAR, own_b, '0);
  endtask

  // fill every entry for one owner, hit the full table, then clear it all
  // while the receiver holds off so the block backs up into the sender
  task automatic test_full_table_and_clear();
    logic [31:0] owner;
    logic [31:0] ptrs [TABLE_DEPTH];
    write_table_size(6'd32);
    owner = $urandom();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      // low bits keep the pointers distinct and nonzero
      ptrs[i] = ($urandom() & ~32'h3F) | 32'(i + 1);
      send_request(REQ_INC, owner, ptrs[i]);
    end
    send_request(REQ_INC, owner, 32'hFFFF_FFC0);
    rsp_hold_len = LONG_HOLD;
    send_request(REQ_CLEAR, owner, '0);
    for (int i = 0; i < 4; i++)
      send_request(REQ_VALID, owner, ptrs[i]);
    send_request(REQ_INC, owner, ptrs[0]);
    drain_results();
  endtask

  // pooled random traffic over several table sizes, idle bursts on both sides
  task automatic test_random_traffic();
    logic [5:0] sizes [7];
    sizes = '{6'd32, 6'd8, 6'd2, 6'd0, SIZE_CODE_MAX, 6'($urandom_range(3, 31)), 6'd33};
    for (int ph = 0; ph < 7; ph++) begin
      write_table_size(sizes[ph]);
      if (ph == 1) rsp_hold_len = LONG_HOLD / 2;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
    end
  endtask

  // closing stretch at full rate with no idling anywhere
  task automatic test_back_to_back();
    write_table_size(6'd32);
    src_gaps_on = 1'b0;
    rsp_gaps_on = 1'b0;
    for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin : test_sequence
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= '0;
    req_bus.owner_id <= '0;
    req_bus.buffer_ptr <= '0;
    src_gaps_on = 1'b1;
    rsp_gaps_on = 1'b1;
    rsp_hold_len = 0;
    mismatch_cnt = 0;
    requests_sent = 0;
    results_seen = 0;
    releases_seen = 0;
    for (int i = 0; i < 8; i++) status_seen[i] = 0;
    reset_table_model();

    // pools: extremes first, then random nonzero pointers
    ptr_pool[0] = 32'hFFFF_FFFF;
    ptr_pool[1] = 32'h0000_0001;
    ptr_pool[2] = 32'h8000_0000;
    for (int i = 3; i < PTR_POOL; i++) ptr_pool[i] = $urandom() | 32'h1;
    owner_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0};
    owner_pool[OWNER_POOL - 1] = $urandom();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_null_and_unknown();
    test_count_lifecycle();
    test_size_limits();
    test_full_table_and_clear();
    test_random_traffic();
    test_back_to_back();

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d results over table sizes 0, 1, 2, 8, 32, 33, 63",
             requests_sent, results_seen);
    $display("releases %0d, full %0d, owner mismatch %0d, not managed %0d, null %0d",
             releases_seen, status_seen[ST_FULL], status_seen[ST_OWNER],
             status_seen[ST_NOTMAN], status_seen[ST_NULL]);
    if (mismatch_cnt == 0 && refcount_results_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // hard stop if the block hangs
  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("timeout with %0d results still pending", refcount_results_q.size());
    $display("Mismatches found");
    $finish;
  end

endmodule
